/* rtl/core/rbci_pkg.sv */
// shared types, constants and the micro-program of the collision impulse block
package rbci_pkg;

   // default configuration
   localparam int WORD_BITS_DEF   = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int QUEUE_DEPTH_DEF = 2;

   // angle conversion constants in Q24.40
   localparam logic [63:0] DEG2RAD_Q40 = 64'd19190098069;
   localparam logic [63:0] RAD2DEG_Q40 = 64'd62997375797124;

   localparam int FLOOR_BITS = 31;
   localparam logic [FLOOR_BITS-1:0] FLOOR_RESET = 31'd1;

   // input item
   typedef struct packed {
      logic               is_second_body;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] arm_x;
      logic signed [31:0] arm_y;
      logic signed [31:0] spin;
      logic [30:0]        inertia;
      logic [30:0]        mass;
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
   } req_type;

   // result item
   typedef struct packed {
      logic               body_id;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic signed [31:0] new_spin;
      logic               last;
      logic               overflow;
   } rsp_type;

   // one collision pair as handed from front to back
   typedef struct packed {
      req_type body_a;
      req_type body_b;
      logic    rot_a;
      logic    rot_b;
   } job_type;

   // queue status toward the front
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // register file addresses
   localparam int RF_ADDR_BITS = 6;
   typedef logic [RF_ADDR_BITS-1:0] raddr_type;

   localparam raddr_type R_VAX  = 6'd0;
   localparam raddr_type R_VAY  = 6'd1;
   localparam raddr_type R_RAX  = 6'd2;
   localparam raddr_type R_RAY  = 6'd3;
   localparam raddr_type R_SA   = 6'd4;
   localparam raddr_type R_MA   = 6'd5;
   localparam raddr_type R_IA   = 6'd6;
   localparam raddr_type R_NX   = 6'd7;
   localparam raddr_type R_NY   = 6'd8;
   localparam raddr_type R_VBX  = 6'd9;
   localparam raddr_type R_VBY  = 6'd10;
   localparam raddr_type R_RBX  = 6'd11;
   localparam raddr_type R_RBY  = 6'd12;
   localparam raddr_type R_SB   = 6'd13;
   localparam raddr_type R_MB   = 6'd14;
   localparam raddr_type R_IB   = 6'd15;
   localparam raddr_type R_ZERO = 6'd16;
   localparam raddr_type R_ONE  = 6'd17;
   localparam raddr_type R_D2R  = 6'd18;
   localparam raddr_type R_R2D  = 6'd19;
   localparam raddr_type R_WA   = 6'd20;
   localparam raddr_type R_WB   = 6'd21;
   localparam raddr_type R_ABX  = 6'd22;
   localparam raddr_type R_ABY  = 6'd23;
   localparam raddr_type R_D    = 6'd24;
   localparam raddr_type R_NN   = 6'd25;
   localparam raddr_type R_DEN  = 6'd26;
   localparam raddr_type R_PA   = 6'd27;
   localparam raddr_type R_PB   = 6'd28;
   localparam raddr_type R_J    = 6'd29;
   localparam raddr_type R_JA   = 6'd30;
   localparam raddr_type R_JB   = 6'd31;
   localparam raddr_type R_T0   = 6'd32;
   localparam raddr_type R_T1   = 6'd33;
   localparam raddr_type R_T2   = 6'd34;
   localparam raddr_type R_SPARE = 6'd35;
   // result registers, kept outside the register file
   localparam raddr_type R_OAX  = 6'd36;
   localparam raddr_type R_OAY  = 6'd37;
   localparam raddr_type R_OSA  = 6'd38;
   localparam raddr_type R_OBX  = 6'd39;
   localparam raddr_type R_OBY  = 6'd40;
   localparam raddr_type R_OSB  = 6'd41;

   localparam int RF_DEPTH = 36;
   localparam int NUM_LOAD = 20;
   localparam int NUM_OUT  = 6;

   // micro-operations
   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_NSUM,
      OP_MUL,
      OP_DIV,
      OP_ENDSEP,
      OP_END
   } op_type;

   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_ROT_A,
      COND_ROT_B
   } cond_type;

   typedef struct packed {
      op_type    op;
      cond_type  cond;
      raddr_type dst;
      raddr_type src_a;
      raddr_type src_b;
   } uop_type;

   localparam int PC_BITS = 6;
   typedef logic [PC_BITS-1:0] pc_type;

   // back end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ISSUE,
      ST_EXEC,
      ST_EMIT_A,
      ST_EMIT_B
   } state_type;

   // collision program; the pass-through results are written before the
   // separation test and overwritten by the impulse path
   function automatic uop_type get_uop(input pc_type pc);
      uop_type u;
      unique case (pc)
         6'd0:  u = '{OP_MUL,  COND_ROT_A,  R_WA,  R_SA,  R_D2R};
         6'd1:  u = '{OP_MUL,  COND_ROT_B,  R_WB,  R_SB,  R_D2R};
         6'd2:  u = '{OP_MUL,  COND_ALWAYS, R_T0,  R_RAX, R_WA};
         6'd3:  u = '{OP_SUB,  COND_ALWAYS, R_T1,  R_VAX, R_T0};
         6'd4:  u = '{OP_MUL,  COND_ALWAYS, R_T0,  R_RBX, R_WB};
         6'd5:  u = '{OP_SUB,  COND_ALWAYS, R_T2,  R_VBX, R_T0};
         6'd6:  u = '{OP_SUB,  COND_ALWAYS, R_ABX, R_T1,  R_T2};
         6'd7:  u = '{OP_MUL,  COND_ALWAYS, R_T0,  R_RAY, R_WA};
         6'd8:  u = '{OP_SUB,  COND_ALWAYS, R_T1,  R_VAY, R_T0};
         6'd9:  u = '{OP_MUL,  COND_ALWAYS, R_T0,  R_RBY, R_WB};
         6'd10: u = '{OP_SUB,  COND_ALWAYS, R_T2,  R_VBY, R_T0};
         6'd11: u = '{OP_SUB,  COND_ALWAYS, R_ABY, R_T1,  R_T2};
         6'd12: u = '{OP_MUL,  COND_ALWAYS, R_T0,  R_ABX, R_NX};
         6'd13: u = '{OP_MUL,  COND_ALWAYS, R_T1,  R_ABY, R_NY};
         6'd14: u = '{OP_ADD,  COND_ALWAYS, R_D,   R_T0,  R_T1};
         6'd15: u = '{OP_ADD,  COND_ALWAYS, R_OAX, R_VAX, R_ZERO};
         6'd16: u = '{OP_ADD,  COND_ALWAYS, R_OAY, R_VAY, R_ZERO};
         6'd17: u = '{OP_ADD,  COND_ROT_A,  R_OSA, R_SA,  R_ZERO};
         6'd18: u = '{OP_ADD,  COND_ALWAYS, R_OBX, R_VBX, R_ZERO};
         6'd19: u = '{OP_ADD,  COND_ALWAYS, R_OBY, R_VBY, R_ZERO};
         6'd20: u = '{OP_ADD,  COND_ROT_B,  R_OSB, R_SB,  R_ZERO};
         6'd21: u = '{OP_ENDSEP, COND_ALWAYS, R_D, R_D,   R_D};
         6'd22: u = '{OP_MUL,  COND_ALWAYS, R_T0,  R_NX,  R_NX};
         6'd23: u = '{OP_MUL,  COND_ALWAYS, R_T1,  R_NY,  R_NY};
         6'd24: u = '{OP_ADD,  COND_ALWAYS, R_NN,  R_T0,  R_T1};
         6'd25: u = '{OP_DIV,  COND_ALWAYS, R_T0,  R_ONE, R_MA};
         6'd26: u = '{OP_DIV,  COND_ALWAYS, R_T1,  R_ONE, R_MB};
         6'd27: u = '{OP_ADD,  COND_ALWAYS, R_T2,  R_T0,  R_T1};
         6'd28: u = '{OP_MUL,  COND_ALWAYS, R_DEN, R_NN,  R_T2};
         6'd29: u = '{OP_MUL,  COND_ALWAYS, R_T0,  R_RAX, R_NX};
         6'd30: u = '{OP_MUL,  COND_ALWAYS, R_T1,  R_RAY, R_NY};
         6'd31: u = '{OP_ADD,  COND_ALWAYS, R_PA,  R_T0,  R_T1};
         6'd32: u = '{OP_MUL,  COND_ALWAYS, R_T0,  R_RBX, R_NX};
         6'd33: u = '{OP_MUL,  COND_ALWAYS, R_T1,  R_RBY, R_NY};
         6'd34: u = '{OP_ADD,  COND_ALWAYS, R_PB,  R_T0,  R_T1};
         6'd35: u = '{OP_MUL,  COND_ALWAYS, R_T0,  R_PA,  R_PA};
         6'd36: u = '{OP_DIV,  COND_ROT_A,  R_T1,  R_T0,  R_IA};
         6'd37: u = '{OP_ADD,  COND_ALWAYS, R_DEN, R_DEN, R_T1};
         6'd38: u = '{OP_MUL,  COND_ALWAYS, R_T0,  R_PB,  R_PB};
         6'd39: u = '{OP_DIV,  COND_ROT_B,  R_T1,  R_T0,  R_IB};
         6'd40: u = '{OP_ADD,  COND_ALWAYS, R_DEN, R_DEN, R_T1};
         6'd41: u = '{OP_NSUM, COND_ALWAYS, R_T2,  R_D,   R_D};
         6'd42: u = '{OP_DIV,  COND_ALWAYS, R_J,   R_T2,  R_DEN};
         6'd43: u = '{OP_DIV,  COND_ALWAYS, R_JA,  R_J,   R_MA};
         6'd44: u = '{OP_DIV,  COND_ALWAYS, R_JB,  R_J,   R_MB};
         6'd45: u = '{OP_MUL,  COND_ALWAYS, R_T0,  R_PA,  R_J};
         6'd46: u = '{OP_DIV,  COND_ROT_A,  R_T1,  R_T0,  R_IA};
         6'd47: u = '{OP_MUL,  COND_ROT_A,  R_T2,  R_T1,  R_R2D};
         6'd48: u = '{OP_SUB,  COND_ROT_A,  R_OSA, R_SA,  R_T2};
         6'd49: u = '{OP_MUL,  COND_ALWAYS, R_T0,  R_PB,  R_J};
         6'd50: u = '{OP_DIV,  COND_ROT_B,  R_T1,  R_T0,  R_IB};
         6'd51: u = '{OP_MUL,  COND_ROT_B,  R_T2,  R_T1,  R_R2D};
         6'd52: u = '{OP_ADD,  COND_ROT_B,  R_OSB, R_SB,  R_T2};
         6'd53: u = '{OP_MUL,  COND_ALWAYS, R_T0,  R_JA,  R_NX};
         6'd54: u = '{OP_ADD,  COND_ALWAYS, R_OAX, R_VAX, R_T0};
         6'd55: u = '{OP_MUL,  COND_ALWAYS, R_T0,  R_JA,  R_NY};
         6'd56: u = '{OP_ADD,  COND_ALWAYS, R_OAY, R_VAY, R_T0};
         6'd57: u = '{OP_MUL,  COND_ALWAYS, R_T0,  R_JB,  R_NX};
         6'd58: u = '{OP_SUB,  COND_ALWAYS, R_OBX, R_VBX, R_T0};
         6'd59: u = '{OP_MUL,  COND_ALWAYS, R_T0,  R_JB,  R_NY};
         6'd60: u = '{OP_SUB,  COND_ALWAYS, R_OBY, R_VBY, R_T0};
         default: u = '{OP_END, COND_ALWAYS, R_SPARE, R_SPARE, R_SPARE};
      endcase
      return u;
   endfunction

endpackage

/* rtl/core/rbci_front.sv */
// front end: holds body a, pairs it with body b and classifies rotation
module rbci_front
   import rbci_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [FLOOR_BITS-1:0] csr_wdata,
   input  qstat_type             q_stat,
   output logic                  push,
   output job_type               push_job
);

   logic                  pending_ff, pending_in;
   logic [FLOOR_BITS-1:0] floor_ff, floor_in;
   req_type               held_ff, held_in;
   logic                  accept;

   // a pairing item waits only when the queue is full
   assign req_stall = req_data.is_second_body & pending_ff & q_stat.full;
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   // pair build and rotation classification
   always_comb begin
      push           = accept & req_data.is_second_body & pending_ff;
      push_job.body_a = held_ff;
      push_job.body_b = req_data;
      push_job.rot_a  = held_ff.inertia > floor_ff;
      push_job.rot_b  = req_data.inertia > floor_ff;
   end

   // next values of held body, pending flag and floor
   always_comb begin
      pending_in = pending_ff;
      held_in    = held_ff;
      floor_in   = floor_ff;
      if (csr_valid) begin
         floor_in = csr_wdata;
      end
      if (accept && !req_data.is_second_body) begin
         held_in    = req_data;
         pending_in = 1'b1;
      end else if (push) begin
         pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         floor_ff   <= FLOOR_RESET;
      end else begin
         pending_ff <= pending_in;
         floor_ff   <= floor_in;
      end
      held_ff <= held_in;
   end

endmodule

/* rtl/core/rbci_queue.sv */
// short job queue between front and back end
module rbci_queue
   import rbci_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  job_type   push_job,
   output qstat_type q_stat,
   input  logic      pop,
   output job_type   head_job
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type         entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign q_stat.full  = count_ff == CW'(DEPTH);
   assign q_stat.empty = count_ff == '0;
   assign head_job     = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* rtl/core/rbci_back.sv */
// back end: micro-coded sequencer with register file, serial multiplier and divider
module rbci_back
   import rbci_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  qstat_type q_stat,
   input  job_type   head_job,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   localparam int W        = WORD_BITS;
   localparam int F        = FRAC_BITS;
   localparam int ND       = (W + 15) / 16;
   localparam int MBW      = ND * 16;
   localparam int AW       = W + MBW;
   localparam int DW       = W + F;
   localparam int CNT_BITS = $clog2(DW + 3);
   localparam int MUL_LAST = ND + 1;
   localparam int DIV_LAST = DW + 1;

   localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};
   localparam logic [63:0]  D2R_RAW = (DEG2RAD_Q40 + (64'd1 << (39 - F))) >> (40 - F);
   localparam logic [63:0]  R2D_RAW = (RAD2DEG_Q40 + (64'd1 << (39 - F))) >> (40 - F);
   localparam logic [63:0]  ONE_RAW = 64'd1 << F;

   // saturate a wide value to the word range
   function automatic logic signed [W-1:0] sat64(input logic signed [63:0] x);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = $signed((64'd1 << (W - 1)) - 64'd1);
      lo = -hi - 64'sd1;
      if (x > hi) begin
         return $signed(hi[W-1:0]);
      end else if (x < lo) begin
         return $signed(lo[W-1:0]);
      end
      return $signed(x[W-1:0]);
   endfunction

   function automatic logic signed [W-1:0] sat_sum(input logic signed [W+1:0] x);
      if (x > $signed({3'b000, {(W-1){1'b1}}})) begin
         return $signed(LIM_POS);
      end else if (x < $signed({3'b111, {(W-1){1'b0}}})) begin
         return $signed(LIM_NEG);
      end
      return $signed(x[W-1:0]);
   endfunction

   function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
      return x[W-1] ? (~x + 1'b1) : x;
   endfunction

   function automatic logic [31:0] to_field(input logic signed [W-1:0] v);
      logic signed [63:0] e;
      e = 64'(v);
      return e[31:0];
   endfunction

   state_type             state_ff, state_in;
   pc_type                pc_ff, pc_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  flag_ff, flag_in;
   logic                  rot_a_ff, rot_a_in;
   logic                  rot_b_ff, rot_b_in;

   logic signed [W-1:0]   rf_mem [RF_DEPTH];
   logic signed [W-1:0]   rd_a_ff, rd_b_ff;
   logic signed [W-1:0]   out_ff [NUM_OUT];
   logic signed [W-1:0]   out_in [NUM_OUT];

   logic [W-1:0]          ma_ff, ma_in;
   logic [MBW-1:0]        mb_ff, mb_in;
   logic [AW-1:0]         acc_ff, acc_in;
   logic                  neg_ff, neg_in;
   logic [DW-1:0]         q_ff, q_in;
   logic [W-1:0]          rem_ff, rem_in;
   logic [W-1:0]          ud_ff, ud_in;

   uop_type               uop;
   logic                  first;
   logic                  cond_ok;
   logic                  exec_done;
   logic                  exec_wr;
   logic                  exec_ovf;
   logic                  exec_stop;
   logic signed [W-1:0]   exec_res;
   logic signed [W+1:0]   sum_ab, diff_ab, nsum_ab;
   logic [AW-F-1:0]       prod_hi;
   logic [W-1:0]          lim;
   logic [W-1:0]          mval, dval;
   logic [W:0]            rem2, rem_sub;
   logic                  rem_ge;
   logic [W+15:0]         partial;

   logic                  rf_we;
   raddr_type             rf_waddr;
   logic signed [W-1:0]   rf_wdata;
   raddr_type             load_addr;
   logic signed [W-1:0]   load_data;
   logic                  rsp_take;

   assign uop       = get_uop(pc_ff);
   assign first     = cnt_ff == '0;
   assign load_addr = raddr_type'(cnt_ff);
   assign rsp_valid = (state_ff == ST_EMIT_A) || (state_ff == ST_EMIT_B);
   assign rsp_take  = rsp_valid & ~rsp_stall;

   // load values from the queue head, saturated to the word
   always_comb begin
      unique case (load_addr)
         R_VAX:   load_data = sat64(64'(head_job.body_a.vel_x));
         R_VAY:   load_data = sat64(64'(head_job.body_a.vel_y));
         R_RAX:   load_data = sat64(64'(head_job.body_a.arm_x));
         R_RAY:   load_data = sat64(64'(head_job.body_a.arm_y));
         R_SA:    load_data = sat64(64'(head_job.body_a.spin));
         R_MA:    load_data = sat64($signed(64'(head_job.body_a.mass)));
         R_IA:    load_data = sat64($signed(64'(head_job.body_a.inertia)));
         R_NX:    load_data = sat64(64'(head_job.body_a.normal_x));
         R_NY:    load_data = sat64(64'(head_job.body_a.normal_y));
         R_VBX:   load_data = sat64(64'(head_job.body_b.vel_x));
         R_VBY:   load_data = sat64(64'(head_job.body_b.vel_y));
         R_RBX:   load_data = sat64(64'(head_job.body_b.arm_x));
         R_RBY:   load_data = sat64(64'(head_job.body_b.arm_y));
         R_SB:    load_data = sat64(64'(head_job.body_b.spin));
         R_MB:    load_data = sat64($signed(64'(head_job.body_b.mass)));
         R_IB:    load_data = sat64($signed(64'(head_job.body_b.inertia)));
         R_ONE:   load_data = sat64($signed(ONE_RAW));
         R_D2R:   load_data = sat64($signed(D2R_RAW));
         R_R2D:   load_data = sat64($signed(R2D_RAW));
         default: load_data = '0;
      endcase
   end

   // arithmetic of the current micro-operation
   always_comb begin
      cond_ok = (uop.cond == COND_ALWAYS) ||
                ((uop.cond == COND_ROT_A) && rot_a_ff) ||
                ((uop.cond == COND_ROT_B) && rot_b_ff);
      sum_ab  = (W+2)'(rd_a_ff) + (W+2)'(rd_b_ff);
      diff_ab = (W+2)'(rd_a_ff) - (W+2)'(rd_b_ff);
      nsum_ab = -sum_ab;
      lim     = neg_ff ? LIM_NEG : LIM_POS;
      prod_hi = acc_ff[AW-1:F];
      mval    = (prod_hi > (AW-F)'(lim)) ? lim : prod_hi[W-1:0];
      dval    = (q_ff > DW'(lim)) ? lim : q_ff[W-1:0];
      partial = ma_ff * mb_ff[MBW-1 -: 16];
      rem2    = {rem_ff, q_ff[DW-1]};
      rem_sub = rem2 - {1'b0, ud_ff};
      rem_ge  = rem2 >= {1'b0, ud_ff};

      exec_done = 1'b1;
      exec_wr   = 1'b0;
      exec_ovf  = 1'b0;
      exec_stop = 1'b0;
      exec_res  = '0;
      if (!cond_ok) begin
         exec_wr = 1'b1;
      end else begin
         unique case (uop.op)
            OP_ADD: begin
               exec_wr  = 1'b1;
               exec_res = sat_sum(sum_ab);
            end
            OP_SUB: begin
               exec_wr  = 1'b1;
               exec_res = sat_sum(diff_ab);
            end
            OP_NSUM: begin
               exec_wr  = 1'b1;
               exec_res = sat_sum(nsum_ab);
            end
            OP_MUL: begin
               exec_done = cnt_ff == CNT_BITS'(MUL_LAST);
               exec_wr   = exec_done;
               exec_res  = neg_ff ? $signed(~mval + 1'b1) : $signed(mval);
            end
            OP_DIV: begin
               if (first && rd_b_ff == '0) begin
                  exec_wr  = 1'b1;
                  exec_ovf = 1'b1;
                  exec_res = rd_a_ff[W-1] ? $signed(LIM_NEG) : $signed(LIM_POS);
               end else begin
                  exec_done = cnt_ff == CNT_BITS'(DIV_LAST);
                  exec_wr   = exec_done;
                  exec_ovf  = exec_done && (q_ff > DW'(lim));
                  exec_res  = neg_ff ? $signed(~dval + 1'b1) : $signed(dval);
               end
            end
            OP_ENDSEP: begin
               exec_stop = ~rd_a_ff[W-1] && (rd_a_ff != '0);
            end
            OP_END: begin
               exec_stop = 1'b1;
            end
            default: begin
               exec_stop = 1'b1;
            end
         endcase
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (cnt_ff == CNT_BITS'(NUM_LOAD - 1)) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: state_in = ST_EXEC;
         ST_EXEC: begin
            if (exec_done) begin
               state_in = exec_stop ? ST_EMIT_A : ST_ISSUE;
            end
         end
         ST_EMIT_A: begin
            if (rsp_take) begin
               state_in = ST_EMIT_B;
            end
         end
         ST_EMIT_B: begin
            if (rsp_take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs and datapath next values
   always_comb begin
      pc_in    = pc_ff;
      cnt_in   = cnt_ff;
      flag_in  = flag_ff;
      rot_a_in = rot_a_ff;
      rot_b_in = rot_b_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      ud_in    = ud_ff;
      for (int i = 0; i < NUM_OUT; i++) begin
         out_in[i] = out_ff[i];
      end
      rf_we    = 1'b0;
      rf_waddr = load_addr;
      rf_wdata = load_data;
      pop      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
         end
         ST_LOAD: begin
            rf_we  = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(NUM_LOAD - 1)) begin
               pop      = 1'b1;
               rot_a_in = head_job.rot_a;
               rot_b_in = head_job.rot_b;
               flag_in  = 1'b0;
               pc_in    = '0;
            end
         end
         ST_ISSUE: begin
            cnt_in = '0;
         end
         ST_EXEC: begin
            cnt_in = cnt_ff + 1'b1;
            // operand capture on the first cycle
            if (first) begin
               neg_in = rd_a_ff[W-1] ^ rd_b_ff[W-1];
               ma_in  = mag(rd_a_ff);
               mb_in  = MBW'(mag(rd_b_ff));
               acc_in = '0;
               q_in   = {mag(rd_a_ff), F'(0)};
               rem_in = '0;
               ud_in  = mag(rd_b_ff);
            end else if (uop.op == OP_MUL) begin
               acc_in = (acc_ff << 16) + AW'(partial);
               mb_in  = mb_ff << 16;
            end else begin
               q_in   = {q_ff[DW-2:0], rem_ge};
               rem_in = rem_ge ? rem_sub[W-1:0] : rem2[W-1:0];
            end
            if (exec_done) begin
               pc_in   = pc_ff + 1'b1;
               flag_in = flag_ff | exec_ovf;
               if (exec_wr) begin
                  if (uop.dst >= R_OAX) begin
                     out_in[3'(uop.dst - R_OAX)] = exec_res;
                  end else begin
                     rf_we    = 1'b1;
                     rf_waddr = uop.dst;
                     rf_wdata = exec_res;
                  end
               end
            end
         end
         ST_EMIT_A, ST_EMIT_B: begin
            cnt_in = '0;
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   // result item from the result registers
   always_comb begin
      rsp_data.body_id  = state_ff == ST_EMIT_B;
      rsp_data.last     = state_ff == ST_EMIT_B;
      rsp_data.overflow = flag_ff;
      if (state_ff == ST_EMIT_B) begin
         rsp_data.new_vel_x = to_field(out_ff[3]);
         rsp_data.new_vel_y = to_field(out_ff[4]);
         rsp_data.new_spin  = to_field(out_ff[5]);
      end else begin
         rsp_data.new_vel_x = to_field(out_ff[0]);
         rsp_data.new_vel_y = to_field(out_ff[1]);
         rsp_data.new_spin  = to_field(out_ff[2]);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         cnt_ff   <= '0;
         flag_ff  <= 1'b0;
         rot_a_ff <= 1'b0;
         rot_b_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         cnt_ff   <= cnt_in;
         flag_ff  <= flag_in;
         rot_a_ff <= rot_a_in;
         rot_b_ff <= rot_b_in;
      end
   end

   // datapath registers and register file
   always_ff @(posedge clock) begin
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      acc_ff <= acc_in;
      neg_ff <= neg_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      ud_ff  <= ud_in;
      for (int i = 0; i < NUM_OUT; i++) begin
         out_ff[i] <= out_in[i];
      end
      if (rf_we) begin
         rf_mem[rf_waddr] <= rf_wdata;
      end
      rd_a_ff <= rf_mem[uop.src_a];
      rd_b_ff <= rf_mem[uop.src_b];
   end

endmodule

/* rtl/core/rigid_body_collision_impulse.sv */
// Planar collision impulse between two rotating rigid bodies. An item with
// is_second_body low stores body A; the next item with it high is body B and
// starts the computation, after which two result items come out, A then B.
// A pair finishes early when the bodies separate and takes longest when the
// impulse is applied at the default Q16.16 format; the one-bit-per-cycle
// divider dominates that case with up to nine divisions, and the serial
// multiplier takes its operand in 16-bit slices. A small queue lets the input
// side keep taking items while a pair is computed and its results wait.
module rigid_body_collision_impulse
   import rbci_pkg::*;
#(
   parameter int WORD_BITS   = WORD_BITS_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [FLOOR_BITS-1:0] csr_wdata
);

   qstat_type q_stat;
   logic      push;
   logic      pop;
   job_type   push_job;
   job_type   head_job;

   // pairing and classification
   rbci_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .q_stat    (q_stat),
      .push      (push),
      .push_job  (push_job)
   );

   // pair queue
   rbci_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .q_stat   (q_stat),
      .pop      (pop),
      .head_job (head_job)
   );

   // impulse computation and result output
   rbci_back #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .head_job  (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // result id and end marker agree
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.body_id == rsp_data.last)
      else $error("body id and last disagree");

   // body b result follows a taken body a result at once
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |=> rsp_valid && rsp_data.last)
      else $error("body b result missing after body a");

   // only a pairing item is ever held back
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> req_data.is_second_body)
      else $error("body a item stalled");

endmodule
